// ===== design/tbp_pkg.sv =====
// Shared types, constants and helper functions for the two-level branch predictor with BTB.
// Used by tbp_ctr_store and two_level_branch_predictor_btb; depends on nothing else.
`timescale 1ns / 1ps

package tbp_pkg;

    localparam int BTB_ENTRIES = 32;
    localparam int MAX_HISTORY = 8;
    localparam int CTR_DEPTH   = 1 << MAX_HISTORY;
    localparam int IDX_W       = $clog2(BTB_ENTRIES + 1) - 1;
    localparam int ROW_W       = (IDX_W > 0) ? IDX_W : 1;
    localparam int BTB_ROWS    = 1 << ROW_W;
    localparam int TAG_W       = 30 - IDX_W;
    localparam int HIST_W      = MAX_HISTORY;
    localparam int HM_W        = HIST_W + 1;
    localparam int LC_AW       = ROW_W + HIST_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_HIST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_TABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIST_BITS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_BITS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CTR_INIT     = 3'd5;

    localparam logic [1:0] SHARE_NONE = 2'd0;
    localparam logic [1:0] SHARE_LOW  = 2'd1;
    localparam logic [1:0] SHARE_HIGH = 2'd2;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    localparam logic [3:0] RST_HIST_BITS = 4'd2;
    localparam logic [4:0] RST_TAG_BITS  = 5'd8;
    localparam logic [1:0] RST_CTR_INIT  = 2'd1;
    localparam logic [1:0] CTR_MAX       = 2'd3;
    localparam logic [1:0] CTR_MIN       = 2'd0;

    typedef struct packed {
        logic        op;
        logic [31:0] pc;
        logic [31:0] target_pc;
        logic        actual_taken;
        logic [31:0] predicted_dst;
    } t_bp_in;

    typedef struct packed {
        logic        pred_taken;
        logic [31:0] pred_target;
        logic [31:0] flush_count;
        logic [31:0] branch_count;
    } t_bp_out;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [31:0]       target;
        logic [HIST_W-1:0] hist;
    } t_btb_entry;

    typedef struct packed {
        logic              rd_en;
        logic [LC_AW-1:0]  rd_local_addr;
        logic [HIST_W-1:0] rd_shared_addr;
        logic              wr_local;
        logic [LC_AW-1:0]  wr_local_addr;
        logic              wr_shared;
        logic [HIST_W-1:0] wr_shared_addr;
        logic [1:0]        wr_data;
        logic              clear;
    } t_ctr_req;

    typedef struct packed {
        logic [1:0] local_ctr;
        logic [1:0] shared_ctr;
    } t_ctr_rsp;

    function automatic logic [ROW_W-1:0] row_of(input logic [31:0] pc);
        logic [31:0] s;
        logic [31:0] m;
        s = pc >> 2;
        m = (32'd1 << IDX_W) - 32'd1;
        return ROW_W'(s & m);
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] pc,
                                                input logic [4:0] tbits);
        logic [31:0] s;
        logic [32:0] m;
        s = pc >> (2 + IDX_W);
        m = (33'd1 << tbits) - 33'd1;
        return TAG_W'(s & m[31:0]);
    endfunction

    function automatic logic [HIST_W-1:0] hist_mask(input logic [3:0] hbits);
        logic [3:0]      h;
        logic [HM_W-1:0] m;
        h = hbits;
        if (h < 4'd1) begin
            h = 4'd1;
        end
        if (h > 4'(MAX_HISTORY)) begin
            h = 4'(MAX_HISTORY);
        end
        m = (HM_W'(1) << h) - HM_W'(1);
        return HIST_W'(m);
    endfunction

    function automatic logic [HIST_W-1:0] xor_src(input logic [31:0] pc,
                                                 input logic [1:0] share);
        logic [HIST_W-1:0] r;
        case (share)
            SHARE_LOW: begin
                r = HIST_W'(pc >> 2);
            end
            SHARE_HIGH: begin
                r = HIST_W'(pc >> 16);
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [1:0] sat_step(input logic [1:0] c, input logic taken);
        logic [1:0] r;
        if (taken) begin
            r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
        end else begin
            r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
        end
        return r;
    endfunction

endpackage

// ===== design/tbp_ctr_store.sv =====
// Counter storage: per-row local counter tables and the shared counter table.
// Depends on tbp_pkg; the shared table reads as the initial value until written.
`timescale 1ns / 1ps

module tbp_ctr_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tbp_pkg::t_ctr_req i_req,
    input  logic [1:0]      i_counter_init,
    output tbp_pkg::t_ctr_rsp o_rsp
);
    import tbp_pkg::*;

    logic [1:0]          local_mem [BTB_ROWS*CTR_DEPTH];
    logic [1:0]          shared_mem [CTR_DEPTH];
    logic [CTR_DEPTH-1:0] r_sh_valid;
    logic [1:0]          r_local_rd;
    logic [1:0]          r_shared_rd;
    logic                r_sh_valid_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_local) begin
            local_mem[i_req.wr_local_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_local_rd <= local_mem[i_req.rd_local_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_shared) begin
            shared_mem[i_req.wr_shared_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_shared_rd   <= shared_mem[i_req.rd_shared_addr];
            r_sh_valid_rd <= r_sh_valid[i_req.rd_shared_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_sh_valid <= '0;
        end else if (i_req.wr_shared) begin
            r_sh_valid[i_req.wr_shared_addr] <= 1'b1;
        end
    end

    assign o_rsp.local_ctr  = r_local_rd;
    assign o_rsp.shared_ctr = r_sh_valid_rd ? r_shared_rd : i_counter_init;

endmodule

// ===== design/two_level_branch_predictor_btb.sv =====
// Top level of the two-level branch predictor with a direct-mapped branch target buffer.
// Depends on tbp_pkg and tbp_ctr_store.
//
//   Channel  | Handshake                   | Payload
//   ---------+-----------------------------+--------------------------
//   input    | i_valid / o_stall           | i_data  (t_bp_in)
//   output   | o_valid / i_stall           | o_data  (t_bp_out)
//   config   | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A transaction passes through BTB read, counter read, then result and write-back.
// An update that allocates a row then sweeps that row's local counter table,
// one counter a cycle, with the input stalled.
// Reset and every known register write invalidate all rows and clear statistics.
// The result register lets a new transaction enter while the last result waits.
`timescale 1ns / 1ps

module two_level_branch_predictor_btb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  tbp_pkg::t_bp_in                i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output tbp_pkg::t_bp_out               o_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tbp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tbp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_BTB   = 4'b0010,
        S_CTR   = 4'b0100,
        S_SWEEP = 4'b1000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic                r_ghm;
    logic                r_gtm;
    logic [1:0]          r_share;
    logic [3:0]          r_hbits;
    logic [4:0]          r_tbits;
    logic [1:0]          r_cinit;
    logic [BTB_ROWS-1:0] r_valid;
    t_btb_entry          btb_mem [BTB_ROWS];
    t_btb_entry          r_btb_rd;
    t_bp_in              r_in;
    logic [ROW_W-1:0]    r_row;
    logic [TAG_W-1:0]    r_tag;
    logic                r_hit;
    logic                r_alloc;
    logic [HIST_W-1:0]   r_ci;
    logic [31:0]         r_btb_target;
    logic [HIST_W-1:0]   r_shist;
    logic [31:0]         r_flush;
    logic [31:0]         r_branch;
    logic [HIST_W-1:0]   r_sweep;
    logic [1:0]          r_step;
    t_bp_out             r_out;
    logic                r_out_valid;

    logic                accept;
    logic                cfg_we;
    logic                cfg_known;
    logic                is_update;
    logic                hit;
    logic                alloc;
    logic [HIST_W-1:0]   hmask;
    logic [HIST_W-1:0]   row_hist;
    logic [HIST_W-1:0]   hist_src;
    logic [HIST_W-1:0]   ci;
    logic [HIST_W-1:0]   new_hist;
    logic                btb_we;
    t_btb_entry          btb_wdata;
    logic [1:0]          ctr_cur;
    logic [1:0]          stepped;
    logic [31:0]         pc4;
    logic                mispred;
    logic                pred_tk;
    logic                out_free;
    logic                deliver;
    logic                sweep_last;
    t_ctr_req            ctr_req;
    t_ctr_rsp            ctr_rsp;
    t_bp_out             n_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_known   = (i_cfg_index == CFG_GLOBAL_HIST) || (i_cfg_index == CFG_GLOBAL_TABLE)
                      || (i_cfg_index == CFG_SHARE_MODE) || (i_cfg_index == CFG_HIST_BITS)
                      || (i_cfg_index == CFG_TAG_BITS) || (i_cfg_index == CFG_CTR_INIT);

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign out_free = !r_out_valid || !i_stall;
    assign deliver  = (r_state == S_CTR) && out_free;
    assign is_update = (r_in.op == OP_UPDATE);

    assign hmask    = hist_mask(r_hbits);
    assign hit      = r_valid[r_row] && (r_btb_rd.tag == r_tag);
    assign alloc    = is_update && !hit;
    assign row_hist = hit ? r_btb_rd.hist : '0;
    assign hist_src = r_ghm ? r_shist : row_hist;
    assign ci       = (hist_src ^ xor_src(r_in.pc, r_share)) & hmask;
    assign new_hist = ((hist_src << 1) | HIST_W'(r_in.actual_taken)) & hmask;

    assign btb_we           = (r_state == S_BTB) && is_update;
    assign btb_wdata.tag    = r_tag;
    assign btb_wdata.target = r_in.target_pc;
    assign btb_wdata.hist   = r_ghm ? row_hist : new_hist;

    assign ctr_cur = r_gtm ? ctr_rsp.shared_ctr : (r_alloc ? r_cinit : ctr_rsp.local_ctr);
    assign stepped = sat_step(ctr_cur, r_in.actual_taken);
    assign pc4     = r_in.pc + 32'd4;
    assign mispred = r_in.actual_taken ? (r_in.target_pc != r_in.predicted_dst)
                                       : (r_in.predicted_dst != pc4);
    assign pred_tk = r_hit && ctr_cur[1];
    assign sweep_last = (r_sweep == HIST_W'(CTR_DEPTH - 1));

    always_comb begin
        if (is_update) begin
            n_out.pred_taken   = 1'b0;
            n_out.pred_target  = '0;
            n_out.flush_count  = r_flush + 32'(mispred);
            n_out.branch_count = r_branch + 32'd1;
        end else begin
            n_out.pred_taken   = pred_tk;
            n_out.pred_target  = pred_tk ? r_btb_target : pc4;
            n_out.flush_count  = r_flush;
            n_out.branch_count = r_branch;
        end
    end

    always_comb begin
        ctr_req.rd_en          = (r_state == S_BTB);
        ctr_req.rd_local_addr  = {r_row, ci};
        ctr_req.rd_shared_addr = ci;
        ctr_req.wr_shared      = deliver && is_update && r_gtm;
        ctr_req.wr_shared_addr = r_ci;
        ctr_req.clear          = cfg_we && cfg_known;
        if (r_state == S_SWEEP) begin
            ctr_req.wr_local      = 1'b1;
            ctr_req.wr_local_addr = {r_row, r_sweep};
            ctr_req.wr_data       = (!r_gtm && (r_sweep == r_ci)) ? r_step : r_cinit;
        end else begin
            ctr_req.wr_local      = deliver && is_update && !r_gtm && !r_alloc;
            ctr_req.wr_local_addr = {r_row, r_ci};
            ctr_req.wr_data       = stepped;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_BTB;
                end
            end
            S_BTB: begin
                n_state = S_CTR;
            end
            S_CTR: begin
                if (out_free) begin
                    n_state = (is_update && r_alloc) ? S_SWEEP : S_IDLE;
                end
            end
            S_SWEEP: begin
                if (sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    tbp_ctr_store u_ctr_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (ctr_req),
        .i_counter_init (r_cinit),
        .o_rsp          (ctr_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (btb_we) begin
            btb_mem[r_row] <= btb_wdata;
        end
        if (accept) begin
            r_btb_rd <= btb_mem[row_of(i_data.pc)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in  <= i_data;
            r_row <= row_of(i_data.pc);
            r_tag <= tag_of(i_data.pc, r_tbits);
        end
        if (r_state == S_BTB) begin
            r_hit        <= hit;
            r_alloc      <= alloc;
            r_ci         <= ci;
            r_btb_target <= r_btb_rd.target;
        end
        if (deliver) begin
            r_out  <= n_out;
            r_step <= stepped;
        end
        if (r_state == S_SWEEP) begin
            r_sweep <= r_sweep + HIST_W'(1);
        end else begin
            r_sweep <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (deliver) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ghm    <= 1'b0;
            r_gtm    <= 1'b0;
            r_share  <= SHARE_NONE;
            r_hbits  <= RST_HIST_BITS;
            r_tbits  <= RST_TAG_BITS;
            r_cinit  <= RST_CTR_INIT;
            r_valid  <= '0;
            r_shist  <= '0;
            r_flush  <= '0;
            r_branch <= '0;
        end else if (cfg_we && cfg_known) begin
            case (i_cfg_index)
                CFG_GLOBAL_HIST: begin
                    r_ghm <= i_cfg_data[0];
                end
                CFG_GLOBAL_TABLE: begin
                    r_gtm <= i_cfg_data[0];
                end
                CFG_SHARE_MODE: begin
                    r_share <= i_cfg_data[1:0];
                end
                CFG_HIST_BITS: begin
                    r_hbits <= i_cfg_data[3:0];
                end
                CFG_TAG_BITS: begin
                    r_tbits <= i_cfg_data[4:0];
                end
                default: begin
                    r_cinit <= i_cfg_data[1:0];
                end
            endcase
            r_valid  <= '0;
            r_shist  <= '0;
            r_flush  <= '0;
            r_branch <= '0;
        end else begin
            if (btb_we) begin
                r_valid[r_row] <= 1'b1;
                if (r_ghm) begin
                    r_shist <= new_hist;
                end
            end
            if (deliver && is_update) begin
                r_flush  <= n_out.flush_count;
                r_branch <= n_out.branch_count;
            end
        end
    end

`ifndef ASSERT_OFF
    a_accept_to_btb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_BTB))
        else $error("accepted transaction did not start a BTB lookup");

    a_result_from_ctr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_CTR))
        else $error("result appeared outside the counter stage");

    a_branch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (deliver && is_update && !cfg_we) |=> (r_branch == $past(r_branch) + 32'd1))
        else $error("branch count did not advance on an update");

    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SWEEP) && sweep_last) |=> (r_state == S_IDLE))
        else $error("row sweep did not end after the last counter");
`endif

endmodule
